FILE: sv/brprm_pkg.sv
// Shared types, codes and constants of the block ring peek/reserve manager.
package brprm_pkg;

    // Field widths of the channels and configuration registers.
    localparam int OP_W    = 4;
    localparam int LEN_W   = 16;
    localparam int SLOT_W  = 4;
    localparam int EV_W    = 3;
    localparam int CNT_W   = 5;
    localparam int BC_W    = 5;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    // Largest block count a 5-bit register can ever select.
    localparam int BC_FIELD_MAX = 31;

    // Defaults and reset values.
    localparam int DEF_MAX_BLOCKS    = 16;
    localparam int RESET_BLOCK_COUNT = 16;
    localparam int RESET_BLOCK_SIZE  = 256;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 4'd0,
        OP_POP     = 4'd1,
        OP_PEEK    = 4'd2,
        OP_UNPEEK  = 4'd3,
        OP_CONSUME = 4'd4,
        OP_RESERVE = 4'd5,
        OP_COMMIT  = 4'd6,
        OP_RELEASE = 4'd7,
        OP_RESET   = 4'd8
    } t_op;

    // Event codes of a result.
    typedef enum logic [EV_W-1:0] {
        EV_NONE      = 3'd0,
        EV_OVERFLOW  = 3'd1,
        EV_UNDERFLOW = 3'd2,
        EV_HALF      = 3'd3,
        EV_EMPTY     = 3'd4,
        EV_FULL      = 3'd5
    } t_event;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_COUNT = 1'd0,
        CFG_BLOCK_SIZE  = 1'd1
    } t_cfg_idx;

    // Classified command handed from the front end to the execution side.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            len_ok;
    } t_cmd;

endpackage

FILE: sv/brprm_in_if.sv
// Operation channel: valid/ready handshake carrying one ring operation.
interface brprm_in_if import brprm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [LEN_W-1:0] length;

    modport source (output valid, output operation, output length, input ready);
    modport sink   (input valid, input operation, input length, output ready);
endinterface

FILE: sv/brprm_out_if.sv
// Result channel: valid/ready handshake carrying one operation result.
interface brprm_out_if import brprm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              ok;
    logic [SLOT_W-1:0] slot_index;
    logic              null_block;
    logic [EV_W-1:0]   event_res;
    logic [CNT_W-1:0]  used_count;

    modport source (output valid, output ok, output slot_index, output null_block,
                    output event_res, output used_count, input ready);
    modport sink   (input valid, input ok, input slot_index, input null_block,
                    input event_res, input used_count, output ready);
endinterface

FILE: sv/block_ring_peek_reserve_manager.sv
// An accepted operation waits in the command queue until the execution stage
// takes it and registers its result. Throughput: one operation per cycle
// while results are taken, set by the pointer and count update of the
// execution stage; the two-entry queue lets either side stall on its own.
// Reset (synchronous, active low) clears all pointers, counts and queues and
// loads block_count 16 and block_size 256; there is no clearing pass.
module block_ring_peek_reserve_manager import brprm_pkg::*; #(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    brprm_in_if.sink             i_op_chan,
    brprm_out_if.source          o_res_chan
);

    localparam int CAP = (MAX_BLOCKS < BC_FIELD_MAX) ? MAX_BLOCKS : BC_FIELD_MAX;
    localparam int CW  = $clog2(CAP + 1);
    localparam int RESET_BC = (RESET_BLOCK_COUNT < CAP) ? RESET_BLOCK_COUNT : CAP;

    logic [CW-1:0]    r_block_count, n_block_count;
    logic [LEN_W-1:0] r_block_size, n_block_size;
    logic [BC_W-1:0]  bc_raw;
    logic [BC_W-1:0]  bc_clamped;
    logic [BC_W+CW-1:0] bc_wide;
    logic             cmd_valid;
    logic             cmd_ready;
    t_cmd             cmd;

    // Configuration writes; the block count is clamped to the supported range.
    always_comb begin
        bc_raw     = i_cfg_data[BC_W-1:0];
        bc_clamped = bc_raw;
        if (bc_raw == '0) begin
            bc_clamped = BC_W'(1);
        end else if (bc_raw > BC_W'(CAP)) begin
            bc_clamped = BC_W'(CAP);
        end
        bc_wide       = {{CW{1'b0}}, bc_clamped};
        n_block_count = r_block_count;
        n_block_size  = r_block_size;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BLOCK_COUNT: n_block_count = bc_wide[CW-1:0];
                CFG_BLOCK_SIZE:  n_block_size  = i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= CW'(RESET_BC);
            r_block_size  <= LEN_W'(RESET_BLOCK_SIZE);
        end else begin
            r_block_count <= n_block_count;
            r_block_size  <= n_block_size;
        end
    end

    brprm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_block_size (r_block_size),
        .i_op_chan    (i_op_chan),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_ready  (cmd_ready)
    );

    brprm_back #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_block_count (r_block_count),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_ready   (cmd_ready),
        .o_res_chan    (o_res_chan)
    );

endmodule

FILE: sv/brprm_front.sv
// Front end: accepts operations, checks the length and queues classified commands.
module brprm_front import brprm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [LEN_W-1:0] i_block_size,
    brprm_in_if.sink         i_op_chan,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd,
    input  logic             i_cmd_ready
);

    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);

    t_cmd             r_mem [QDEPTH];
    logic [QPW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QPW:0]     r_count, n_count;
    t_cmd             cmd_in;
    logic             push;
    logic             pop;

    // Classify the incoming operation.
    always_comb begin
        cmd_in.op     = i_op_chan.operation;
        cmd_in.len_ok = (i_op_chan.length == i_block_size);
    end

    assign i_op_chan.ready = (r_count != (QPW+1)'(QDEPTH));
    assign push            = i_op_chan.valid && i_op_chan.ready;
    assign o_cmd_valid     = (r_count != '0);
    assign pop             = o_cmd_valid && i_cmd_ready;
    assign o_cmd           = r_mem[r_rd_ptr];

    // Queue pointer and fill bookkeeping.
    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + QPW'(1) : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + QPW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + (QPW+1)'(1);
        end else if (pop && !push) begin
            n_count = r_count - (QPW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

FILE: sv/brprm_back.sv
// Back end: keeps the ring pointers and counts and registers one result per command.
module brprm_back import brprm_pkg::*; #(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic [$clog2((MAX_BLOCKS < BC_FIELD_MAX ? MAX_BLOCKS : BC_FIELD_MAX) + 1)-1:0]
                 i_block_count,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_ready,
    brprm_out_if.source o_res_chan
);

    localparam int CAP = (MAX_BLOCKS < BC_FIELD_MAX) ? MAX_BLOCKS : BC_FIELD_MAX;
    localparam int PW  = $clog2(CAP);
    localparam int CW  = $clog2(CAP + 1);

    logic [PW-1:0] r_start, n_start;
    logic [PW-1:0] r_end, n_end;
    logic [PW-1:0] r_peek, n_peek;
    logic [PW-1:0] r_resv, n_resv;
    logic [CW-1:0] r_used, n_used;
    logic [CW-1:0] r_peeked, n_peeked;
    logic [CW-1:0] r_reserved, n_reserved;

    logic              r_out_valid, n_out_valid;
    logic              r_ok, n_ok;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_null, n_null;
    logic [EV_W-1:0]   r_event, n_event;
    logic [CNT_W-1:0]  r_used_out, n_used_out;

    logic              fire;
    logic              full;
    logic [CW-1:0]     room;
    logic [CW:0]       commit_sum;
    logic [PW-1:0]     slot_pick;
    logic [SLOT_W+PW-1:0] slot_wide;
    logic [CNT_W+CW-1:0]  used_wide;

    // Step a slot pointer forward, wrapping at the current block count.
    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                              input logic [CW-1:0] bc);
        logic [CW:0] nxt;
        nxt = {{(CW+1-PW){1'b0}}, p} + (CW+1)'(1);
        return (nxt >= {1'b0, bc}) ? '0 : nxt[PW-1:0];
    endfunction

    // Event raised from the committed count after a state-changing operation.
    function automatic logic [EV_W-1:0] state_event(input logic [CW-1:0] used,
                                                    input logic [CW-1:0] bc);
        logic [EV_W-1:0] ev;
        if (used == (bc >> 1)) begin
            ev = EV_HALF;
        end else if (used == '0) begin
            ev = EV_EMPTY;
        end else if (used >= bc) begin
            ev = EV_FULL;
        end else begin
            ev = EV_NONE;
        end
        return ev;
    endfunction

    assign fire        = i_cmd_valid && (!r_out_valid || o_res_chan.ready);
    assign o_cmd_ready = fire;
    assign full        = (r_used >= i_block_count);
    assign room        = full ? '0 : i_block_count - r_used;
    assign commit_sum  = {1'b0, r_used} + {1'b0, r_reserved};

    // Execute one command against the ring state.
    always_comb begin
        n_start    = r_start;
        n_end      = r_end;
        n_peek     = r_peek;
        n_resv     = r_resv;
        n_used     = r_used;
        n_peeked   = r_peeked;
        n_reserved = r_reserved;
        n_ok       = 1'b0;
        n_null     = 1'b0;
        n_event    = EV_NONE;
        slot_pick  = '0;

        case (t_op'(i_cmd.op))
            OP_PUSH: begin
                if (i_cmd.len_ok && (r_end == r_resv)) begin
                    if (full) begin
                        n_event = EV_OVERFLOW;
                    end else begin
                        slot_pick = r_end;
                        n_end     = advance(r_end, i_block_count);
                        n_resv    = n_end;
                        n_used    = r_used + CW'(1);
                        n_ok      = 1'b1;
                        n_event   = state_event(n_used, i_block_count);
                    end
                end
            end
            OP_POP: begin
                if (i_cmd.len_ok && (r_start == r_peek)) begin
                    if (r_used == '0) begin
                        n_null  = 1'b1;
                        n_event = EV_UNDERFLOW;
                    end else begin
                        slot_pick = r_start;
                        n_start   = advance(r_start, i_block_count);
                        n_peek    = n_start;
                        n_used    = r_used - CW'(1);
                        n_ok      = 1'b1;
                        n_event   = state_event(n_used, i_block_count);
                    end
                end
            end
            OP_PEEK: begin
                if (r_peeked < r_used) begin
                    slot_pick = r_peek;
                    n_peek    = advance(r_peek, i_block_count);
                    n_peeked  = r_peeked + CW'(1);
                    n_ok      = 1'b1;
                end else begin
                    n_null  = 1'b1;
                    n_event = EV_UNDERFLOW;
                end
            end
            OP_UNPEEK: begin
                n_peek   = r_start;
                n_peeked = '0;
                n_ok     = 1'b1;
            end
            OP_CONSUME: begin
                n_used   = (r_peeked > r_used) ? '0 : r_used - r_peeked;
                n_peeked = '0;
                n_start  = r_peek;
                n_ok     = 1'b1;
                n_event  = state_event(n_used, i_block_count);
            end
            OP_RESERVE: begin
                if (room > r_reserved) begin
                    slot_pick  = r_resv;
                    n_resv     = advance(r_resv, i_block_count);
                    n_reserved = r_reserved + CW'(1);
                    n_ok       = 1'b1;
                end else begin
                    // No room left: restart the reservation at the peek pointer.
                    n_used     = '0;
                    n_end      = r_peek;
                    n_reserved = CW'(1);
                    slot_pick  = r_peek;
                    n_resv     = advance(r_peek, i_block_count);
                    n_event    = EV_OVERFLOW;
                end
            end
            OP_COMMIT: begin
                n_used     = (commit_sum > {1'b0, i_block_count}) ? i_block_count
                                                                  : commit_sum[CW-1:0];
                n_reserved = '0;
                n_end      = r_resv;
                n_ok       = 1'b1;
                n_event    = state_event(n_used, i_block_count);
            end
            OP_RELEASE: begin
                n_reserved = '0;
                n_resv     = r_end;
                n_ok       = 1'b1;
            end
            OP_RESET: begin
                n_start    = '0;
                n_end      = '0;
                n_peek     = '0;
                n_resv     = '0;
                n_used     = '0;
                n_peeked   = '0;
                n_reserved = '0;
                n_ok       = 1'b1;
            end
            default: begin
            end
        endcase

        slot_wide  = {{SLOT_W{1'b0}}, slot_pick};
        used_wide  = {{CNT_W{1'b0}}, n_used};
        n_slot     = slot_wide[SLOT_W-1:0];
        n_used_out = used_wide[CNT_W-1:0];
    end

    // Output register valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (o_res_chan.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Ring state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_end       <= '0;
            r_peek      <= '0;
            r_resv      <= '0;
            r_used      <= '0;
            r_peeked    <= '0;
            r_reserved  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (fire) begin
                r_start    <= n_start;
                r_end      <= n_end;
                r_peek     <= n_peek;
                r_resv     <= n_resv;
                r_used     <= n_used;
                r_peeked   <= n_peeked;
                r_reserved <= n_reserved;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_ok       <= n_ok;
            r_slot     <= n_slot;
            r_null     <= n_null;
            r_event    <= n_event;
            r_used_out <= n_used_out;
        end
    end

    assign o_res_chan.valid      = r_out_valid;
    assign o_res_chan.ok         = r_ok;
    assign o_res_chan.slot_index = r_slot;
    assign o_res_chan.null_block = r_null;
    assign o_res_chan.event_res  = r_event;
    assign o_res_chan.used_count = r_used_out;

endmodule

FILE: test/tb.sv
// Self-checking testbench for the block ring peek/reserve manager.
`timescale 1ns / 100ps

module tb import brprm_pkg::*; ();

    // Operation codes outside the defined set; the block must leave its state alone.
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd9;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 143;
    localparam int STALL_LIMIT     = 2000;
    localparam int REPORT_LIMIT    = 10;

    // One expected result of the ring manager.
    typedef struct {
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic              null_blk;
        t_event            ev;
        logic [CNT_W-1:0]  used;
    } t_ring_result;

    // Tracks the ring pointers and counts and checks each result against them.
    class ring_index_tracker;
        int unsigned  blocks;
        int unsigned  bsize;
        int unsigned  head_slot;
        int unsigned  tail_slot;
        int unsigned  peek_at;
        int unsigned  resv_at;
        int unsigned  used;
        int unsigned  peeked;
        int unsigned  reserved;
        t_ring_result due_results[$];
        int           errors;

        function new();
            blocks = RESET_BLOCK_COUNT;
            bsize  = RESET_BLOCK_SIZE;
            errors = 0;
            clear_ring();
        endfunction

        function void clear_ring();
            head_slot = 0;
            tail_slot = 0;
            peek_at   = 0;
            resv_at   = 0;
            used      = 0;
            peeked    = 0;
            reserved  = 0;
        endfunction

        // The block count register is clamped to the ring capacity.
        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            int unsigned v;
            if (idx == CFG_BLOCK_COUNT) begin
                v = data & BC_FIELD_MAX;
                if (v < 1) v = 1;
                if (v > DEF_MAX_BLOCKS) v = DEF_MAX_BLOCKS;
                blocks = v;
            end else begin
                bsize = 32'(data);
            end
        endfunction

        // A pointer at or past the ring end wraps to slot zero.
        function int unsigned next_slot(int unsigned p);
            return (p + 1 >= blocks) ? 0 : p + 1;
        endfunction

        function t_event fill_event();
            if (used == blocks / 2) return EV_HALF;
            if (used == 0) return EV_EMPTY;
            if (used >= blocks) return EV_FULL;
            return EV_NONE;
        endfunction

        // Applies one accepted operation and queues the result it must give.
        function void note_operation(logic [OP_W-1:0] op, logic [LEN_W-1:0] len);
            t_ring_result r;
            int unsigned  room;
            r.ok       = 1'b0;
            r.slot     = '0;
            r.null_blk = 1'b0;
            r.ev       = EV_NONE;
            case (op)
                OP_PUSH: begin
                    if (len == bsize && tail_slot == resv_at) begin
                        if (used >= blocks) begin
                            r.ev = EV_OVERFLOW;
                        end else begin
                            r.slot    = SLOT_W'(tail_slot);
                            tail_slot = next_slot(tail_slot);
                            used++;
                            resv_at   = tail_slot;
                            r.ok      = 1'b1;
                            r.ev      = fill_event();
                        end
                    end
                end
                OP_POP: begin
                    if (len == bsize && head_slot == peek_at) begin
                        if (used == 0) begin
                            r.null_blk = 1'b1;
                            r.ev       = EV_UNDERFLOW;
                        end else begin
                            r.slot    = SLOT_W'(head_slot);
                            head_slot = next_slot(head_slot);
                            used--;
                            peek_at   = head_slot;
                            r.ok      = 1'b1;
                            r.ev      = fill_event();
                        end
                    end
                end
                OP_PEEK: begin
                    if (peeked < used) begin
                        r.slot  = SLOT_W'(peek_at);
                        peek_at = next_slot(peek_at);
                        peeked++;
                        r.ok    = 1'b1;
                    end else begin
                        r.null_blk = 1'b1;
                        r.ev       = EV_UNDERFLOW;
                    end
                end
                OP_UNPEEK: begin
                    peek_at = head_slot;
                    peeked  = 0;
                    r.ok    = 1'b1;
                end
                OP_CONSUME: begin
                    used      = (peeked > used) ? 0 : used - peeked;
                    peeked    = 0;
                    head_slot = peek_at;
                    r.ok      = 1'b1;
                    r.ev      = fill_event();
                end
                OP_RESERVE: begin
                    room = (used >= blocks) ? 0 : blocks - used;
                    if (room > reserved) begin
                        r.slot  = SLOT_W'(resv_at);
                        resv_at = next_slot(resv_at);
                        reserved++;
                        r.ok    = 1'b1;
                    end else begin
                        // No room left: the ring restarts at the peek pointer.
                        used      = 0;
                        tail_slot = peek_at;
                        reserved  = 1;
                        r.slot    = SLOT_W'(peek_at);
                        resv_at   = next_slot(peek_at);
                        r.ev      = EV_OVERFLOW;
                    end
                end
                OP_COMMIT: begin
                    used += reserved;
                    if (used > blocks) used = blocks;
                    reserved  = 0;
                    tail_slot = resv_at;
                    r.ok      = 1'b1;
                    r.ev      = fill_event();
                end
                OP_RELEASE: begin
                    reserved = 0;
                    resv_at  = tail_slot;
                    r.ok     = 1'b1;
                end
                OP_RESET: begin
                    clear_ring();
                    r.ok = 1'b1;
                end
                default: ;
            endcase
            r.used = CNT_W'(used);
            due_results.insert(due_results.size(), r);
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= REPORT_LIMIT) $display("tb: mismatch: %s", msg);
        endfunction

        // Compares one result transaction with the oldest expectation.
        function void check_result(logic ok, logic [SLOT_W-1:0] slot, logic null_blk,
                                   logic [EV_W-1:0] ev, logic [CNT_W-1:0] used_cnt);
            t_ring_result e;
            if (due_results.size() == 0) begin
                report($sformatf("result with none expected (ok %0b slot %0d)", ok, slot));
                return;
            end
            e = due_results.pop_front();
            if (ok !== e.ok || slot !== e.slot || null_blk !== e.null_blk ||
                ev !== e.ev || used_cnt !== e.used) begin
                report($sformatf({"expected ok %0b slot %0d null %0b event %0d used %0d, ",
                                  "got ok %0b slot %0d null %0b event %0d used %0d"},
                                 e.ok, e.slot, e.null_blk, e.ev, e.used,
                                 ok, slot, null_blk, ev, used_cnt));
            end
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    brprm_in_if  op_chan ();
    brprm_out_if res_chan ();

    ring_index_tracker tracker = new();

    bit allow_gaps = 1'b1;
    int stall_left = 0;
    int quiet_cycles = 0;

    block_ring_peek_reserve_manager uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op_chan   (op_chan),
        .o_res_chan  (res_chan)
    );

    always #4 i_clk = ~i_clk;

    // Result side: ready drops for random bursts while gaps are allowed.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            res_chan.ready <= 1'b0;
        end else if (allow_gaps && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            res_chan.ready <= 1'b0;
        end else begin
            res_chan.ready <= 1'b1;
        end
    end

    // Every accepted result transaction is checked at the edge that takes it.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_chan.valid === 1'b1 && res_chan.ready === 1'b1) begin
            tracker.check_result(res_chan.ok, res_chan.slot_index, res_chan.null_block,
                                 res_chan.event_res, res_chan.used_count);
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if ((op_chan.valid === 1'b1 && op_chan.ready === 1'b1) ||
            (res_chan.valid === 1'b1 && res_chan.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Writes both ring registers; only called while the block is idle.
    task automatic configure(logic [CFG_W-1:0] count, logic [CFG_W-1:0] size);
        tracker.write_reg(CFG_BLOCK_COUNT, count);
        tracker.write_reg(CFG_BLOCK_SIZE, size);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BLOCK_COUNT;
        i_cfg_data  <= count;
        @(posedge i_clk);
        i_cfg_index <= CFG_BLOCK_SIZE;
        i_cfg_data  <= size;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Presents one operation, optionally after a gap, and waits for its acceptance.
    task automatic send_op(logic [OP_W-1:0] op, logic [LEN_W-1:0] len);
        if (allow_gaps && $urandom_range(0, 4) == 0) begin
            op_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        op_chan.valid     <= 1'b1;
        op_chan.operation <= op;
        op_chan.length    <= len;
        @(posedge i_clk);
        while (op_chan.ready !== 1'b1) @(posedge i_clk);
        tracker.note_operation(op, len);
    endtask

    // Holds off new operations until every expected result has come back.
    task automatic drain_results();
        op_chan.valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Weighted operation choice; the mode leans toward filling, emptying or peek/reserve.
    function automatic logic [OP_W-1:0] pick_op(int mode);
        int   cut [3][9] = '{'{40, 55, 65, 75, 83, 88, 92, 96, 97},
                             '{12, 17, 21, 55, 75, 85, 92, 96, 97},
                             '{15, 35, 45, 55, 75, 85, 90, 95, 97}};
        t_op  order [9]  = '{OP_PUSH, OP_RESERVE, OP_COMMIT, OP_POP, OP_PEEK,
                             OP_CONSUME, OP_UNPEEK, OP_RELEASE, OP_RESET};
        int   r;
        r = $urandom_range(0, 99);
        for (int i = 0; i < 9; i++) begin
            if (r < cut[mode][i]) return order[i];
        end
        return OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    endfunction

    // Mostly the matching length, sometimes a random or one-bit-off one.
    function automatic logic [LEN_W-1:0] pick_len(logic [LEN_W-1:0] size);
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return size;
        if (r < 93) return LEN_W'($urandom_range(0, 65535));
        return size ^ (16'h1 << $urandom_range(0, LEN_W - 1));
    endfunction

    initial begin
        logic [CFG_W-1:0] count_tab [NUM_PHASES] = '{16, 1, 2, 0, 5, 31, 3, 4};
        logic [CFG_W-1:0] size_tab  [NUM_PHASES] = '{16'd256, 16'd1, 16'hFFFF, 16'h00F0,
                                                    16'h5A5A, 16'h8000, 16'h7FFF, 16'h0003};
        logic [LEN_W-1:0] bs;
        int               mode;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = CFG_BLOCK_COUNT;
        i_cfg_data        = '0;
        op_chan.valid     = 1'b0;
        op_chan.operation = OP_PUSH;
        op_chan.length    = '0;
        mode              = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk through a two-block ring: every operation and corner case.
        bs = 16'h1234;
        configure(2, bs);
        send_op(OP_POP, bs);             // empty ring underflow
        send_op(OP_PEEK, 16'h0000);      // nothing to peek
        send_op(OP_PUSH, 16'h0000);      // length mismatch
        send_op(OP_PUSH, 16'hFFFF);      // length mismatch
        send_op(OP_PUSH, bs);            // half used
        send_op(OP_PUSH, bs);            // full
        send_op(OP_PUSH, bs);            // overflow
        send_op(OP_PEEK, bs);
        send_op(OP_POP, bs);             // rejected while a peek is open
        send_op(OP_UNPEEK, bs);
        send_op(OP_POP, bs);
        send_op(OP_PEEK, bs);
        send_op(OP_CONSUME, bs);         // back to empty
        send_op(OP_RESERVE, bs);
        send_op(OP_PUSH, bs);            // rejected while a reservation is open
        send_op(OP_RELEASE, bs);
        send_op(OP_RESERVE, bs);
        send_op(OP_RESERVE, bs);
        send_op(OP_RESERVE, bs);         // no room: ring restarts at the peek pointer
        send_op(OP_COMMIT, bs);
        send_op(OP_UNUSED_LO, bs);
        send_op(OP_RESET, bs);
        send_op(OP_UNUSED_HI, 16'hFFFF);
        send_op(OP_POP, bs);

        // Random phases; the ring is reconfigured without a reset so pointers may sit
        // beyond a shrunk ring end.
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            configure(count_tab[p], size_tab[p]);
            if (p == NUM_PHASES - 1) allow_gaps = 1'b0;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k % 20 == 0) mode = $urandom_range(0, 2);
                if (k == ITEMS_PER_PHASE / 2 && p % 2 == 1 && p < NUM_PHASES - 1) begin
                    drain_results();
                end
                send_op(pick_op(mode), pick_len(tracker.bsize));
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/brprm_pkg.sv
sv/brprm_in_if.sv
sv/brprm_out_if.sv
sv/brprm_front.sv
sv/brprm_back.sv
sv/block_ring_peek_reserve_manager.sv
test/tb.sv
